### rtl/core/tpt_pkg.sv
// Shared types and constants for the TLB / page table translator.
// No dependencies; used by the top level.
package tpt_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 16;
  localparam int FRAME_W = 8;
  localparam int CNT_W   = 32;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/tpt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/tlb_page_table_translator_unit.sv
// TLB with FIFO replacement in front of a demand-paged page table.
// Each word passes through the lookup state (TLB compare with page table read), then the
// finish state (resolve with write back), which loads the result word register.
// A new word is accepted only in the idle state, once the last one is finished; a stalled result holds
// the next word in the finish state until the result is taken.
// Reset (rst, synchronous, active high) invalidates TLB and page table, zeroes counts.
module tlb_page_table_translator_unit #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tpt_pkg::ADDR_W-1:0] logical_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tpt_pkg::ADDR_W-1:0] physical_address,
  output logic [tpt_pkg::FRAME_W-1:0] frame_number,
  output logic                       tlb_hit,
  output logic                       page_fault,
  output logic [tpt_pkg::CNT_W-1:0]  hit_total,
  output logic [tpt_pkg::CNT_W-1:0]  fault_total
);

  localparam int PIN_W       = tpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int PIDX        = $clog2(PAGE_COUNT);
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / PAGE_COUNT + 1;
  localparam int PROD_W      = PIN_W + RECIP_SHIFT + 1;
  localparam int QN_W        = PIN_W + 9;
  localparam int PHYS_W      = tpt_pkg::FRAME_W + OFFSET_BITS;

  tpt_pkg::state_t state, state_next;
  logic lookup_en, finish_en;

  // Input stage registers and the reciprocal product
  logic [tpt_pkg::ADDR_W-1:0] addr_reg;
  logic [PIN_W-1:0]           quot_reg;
  logic [PROD_W-1:0]          recip_prod;

  // Lookup stage registers
  logic [PIDX-1:0]             page_reg;
  logic                        hit_reg;
  logic [tpt_pkg::FRAME_W-1:0] hit_frame_reg;
  logic                        pv_reg;

  // TLB and page table state
  logic [PIDX-1:0]             tlb_page  [TLB_ENTRIES];
  logic [tpt_pkg::FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]      tlb_valid;
  logic [PAGE_COUNT-1:0]       page_valid;
  logic [PIDX-1:0]             next_frame;
  logic [tpt_pkg::CNT_W-1:0]   hit_count;
  logic [tpt_pkg::CNT_W-1:0]   fault_count;

  logic [QN_W-1:0]             quot_n;
  logic [QN_W-1:0]             rem_wide;
  logic [PIDX-1:0]             page_cur;
  logic                        tlb_match;
  logic [tpt_pkg::FRAME_W-1:0] tlb_match_frame;
  logic [tpt_pkg::FRAME_W-1:0] ram_rdata;
  logic [tpt_pkg::FRAME_W-1:0] frame_sel;
  logic                        fault_sel;
  logic [PHYS_W-1:0]           phys_full;
  logic [31:0]                 phys_wide;

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    lookup_en  = 1'b0;
    finish_en  = 1'b0;
    unique case (state)
      tpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = tpt_pkg::ST_LOOKUP;
        end
      end
      tpt_pkg::ST_LOOKUP: begin
        lookup_en  = 1'b1;
        state_next = tpt_pkg::ST_FINISH;
      end
      tpt_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          finish_en  = 1'b1;
          state_next = tpt_pkg::ST_IDLE;
        end
      end
      default: state_next = tpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Quotient of page number by page count via reciprocal multiply
  assign recip_prod = PROD_W'(logical_address[tpt_pkg::ADDR_W-1:OFFSET_BITS]) *
                      PROD_W'(RECIP);

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_reg <= logical_address;
      quot_reg <= recip_prod[RECIP_SHIFT +: PIN_W];
    end
  end

  // Remainder gives the page table index
  assign quot_n   = QN_W'(quot_reg) * QN_W'(PAGE_COUNT);
  assign rem_wide = QN_W'(addr_reg[tpt_pkg::ADDR_W-1:OFFSET_BITS]) - quot_n;
  assign page_cur = rem_wide[PIDX-1:0];

  // Search the TLB; the highest (newest) matching entry wins
  always_comb begin
    tlb_match       = 1'b0;
    tlb_match_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid[i] && tlb_page[i] == page_cur) begin
        tlb_match       = 1'b1;
        tlb_match_frame = tlb_frame[i];
      end
    end
  end

  // Hold lookup results for the resolve cycle
  always_ff @(posedge clk) begin
    if (lookup_en) begin
      page_reg      <= page_cur;
      hit_reg       <= tlb_match;
      hit_frame_reg <= tlb_match_frame;
      pv_reg        <= page_valid[page_cur];
    end
  end

  // Resolve the frame: TLB hit, page table entry, or a fresh frame
  always_comb begin
    fault_sel = !hit_reg && !pv_reg;
    priority if (hit_reg) begin
      frame_sel = hit_frame_reg;
    end else if (pv_reg) begin
      frame_sel = ram_rdata;
    end else begin
      frame_sel = tpt_pkg::FRAME_W'(next_frame);
    end
  end

  tpt_ram #(
    .WIDTH(tpt_pkg::FRAME_W),
    .DEPTH(PAGE_COUNT)
  ) u_page_ram (
    .clk  (clk),
    .we   (finish_en && fault_sel),
    .waddr(page_reg),
    .wdata(frame_sel),
    .re   (lookup_en),
    .raddr(page_cur),
    .rdata(ram_rdata)
  );

  // Page valid bits, frame counter and running counts
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid  <= '0;
      next_frame  <= '0;
      hit_count   <= '0;
      fault_count <= '0;
    end else if (finish_en) begin
      if (hit_reg) begin
        hit_count <= hit_count + 1'b1;
      end
      if (fault_sel) begin
        page_valid[page_reg] <= 1'b1;
        fault_count          <= fault_count + 1'b1;
        if (next_frame == PIDX'(PAGE_COUNT - 1)) begin
          next_frame <= '0;
        end else begin
          next_frame <= next_frame + 1'b1;
        end
      end
    end
  end

  // Push a miss into the TLB as newest entry; oldest drops out
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
    end else if (finish_en && !hit_reg) begin
      tlb_valid <= {1'b1, tlb_valid[TLB_ENTRIES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en && !hit_reg) begin
      for (int i = 0; i < TLB_ENTRIES - 1; i++) begin
        tlb_page[i]  <= tlb_page[i + 1];
        tlb_frame[i] <= tlb_frame[i + 1];
      end
      tlb_page[TLB_ENTRIES-1]  <= page_reg;
      tlb_frame[TLB_ENTRIES-1] <= frame_sel;
    end
  end

  // Output word register
  assign phys_full = {frame_sel, addr_reg[OFFSET_BITS-1:0]};
  assign phys_wide = 32'(phys_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en) begin
      physical_address <= phys_wide[tpt_pkg::ADDR_W-1:0];
      frame_number     <= frame_sel;
      tlb_hit          <= hit_reg;
      page_fault       <= fault_sel;
    end
  end

  // Counts change only when a result word is loaded
  assign hit_total   = hit_count;
  assign fault_total = fault_count;

`ifndef SYNTHESIS
  // A result word is never both a TLB hit and a page fault
  a_hit_xor_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("result word flags both TLB hit and page fault");

  // The hit count advances by exactly the hit flag of the new word
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    finish_en |=> (hit_total - $past(hit_total)) == tpt_pkg::CNT_W'(tlb_hit))
    else $error("hit count out of step with result word");

  // A fault leaves its page marked valid
  a_fault_marks: assert property (@(posedge clk) disable iff (rst)
    (finish_en && fault_sel) |=> page_valid[$past(page_reg)])
    else $error("faulted page not marked valid");

  // An accepted word blocks the input until it is resolved
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for tlb_page_table_translator_unit: TLB lookup, page table fill and FIFO refill.
// Holds a translation scoreboard package and the top module tb; depends on tpt_pkg and the RTL.
package translate_check_pkg;

  localparam int ADDR_W     = tpt_pkg::ADDR_W;
  localparam int FRAME_W    = tpt_pkg::FRAME_W;
  localparam int CNT_W      = tpt_pkg::CNT_W;
  localparam int TLB_DEPTH  = 16;
  localparam int PAGE_SLOTS = 256;
  localparam int OFFSET_W   = 8;

  typedef struct {
    logic [ADDR_W-1:0]  phys;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fault;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   faults;
  } translation_t;

  class translation_scoreboard;
    // Own copy of the TLB (newest entry at the top index) and the page table
    bit [FRAME_W-1:0] tlb_page  [TLB_DEPTH];
    bit [FRAME_W-1:0] tlb_frame [TLB_DEPTH];
    bit               tlb_live  [TLB_DEPTH];
    bit [FRAME_W-1:0] frame_of_page [PAGE_SLOTS];
    bit               page_mapped   [PAGE_SLOTS];
    int               frame_cursor;
    bit [CNT_W-1:0]   hit_cnt;
    bit [CNT_W-1:0]   fault_cnt;

    translation_t     pending_translations[$];
    int               errors;
    int               words_checked;
    int               table_hits;

    function int pending();
      return pending_translations.size();
    endfunction

    // Work out the result word for one address and advance the state
    function translation_t translate(logic [ADDR_W-1:0] addr);
      translation_t t;
      int page;
      int offset;
      int slot;
      bit found;
      page   = (int'(addr) >> OFFSET_W) % PAGE_SLOTS;
      offset = int'(addr) & ((1 << OFFSET_W) - 1);
      found  = 1'b0;
      t.frame = '0;
      t.fault = 1'b0;

      // search newest to oldest, first valid match wins
      for (slot = TLB_DEPTH - 1; slot >= 0; slot--) begin
        if (!found && tlb_live[slot] && tlb_page[slot] == FRAME_W'(page)) begin
          found   = 1'b1;
          t.frame = tlb_frame[slot];
        end
      end

      if (found) begin
        hit_cnt++;
      end else begin
        if (page_mapped[page]) begin
          t.frame = frame_of_page[page];
          table_hits++;
        end else begin
          // assign the next frame and wrap the counter
          t.fault = 1'b1;
          fault_cnt++;
          t.frame = FRAME_W'(frame_cursor);
          frame_of_page[page] = t.frame;
          page_mapped[page]   = 1'b1;
          frame_cursor = (frame_cursor + 1 >= PAGE_SLOTS) ? 0 : frame_cursor + 1;
        end
        // shift out the oldest entry, push the miss as newest
        for (slot = 0; slot < TLB_DEPTH - 1; slot++) begin
          tlb_page[slot]  = tlb_page[slot + 1];
          tlb_frame[slot] = tlb_frame[slot + 1];
          tlb_live[slot]  = tlb_live[slot + 1];
        end
        tlb_page[TLB_DEPTH - 1]  = FRAME_W'(page);
        tlb_frame[TLB_DEPTH - 1] = t.frame;
        tlb_live[TLB_DEPTH - 1]  = 1'b1;
      end

      t.hit    = found;
      t.phys   = ADDR_W'((int'(t.frame) << OFFSET_W) | offset);
      t.hits   = hit_cnt;
      t.faults = fault_cnt;
      return t;
    endfunction

    function void note_address(logic [ADDR_W-1:0] addr);
      pending_translations.push_back(translate(addr));
    endfunction

    function void compare_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(logic [ADDR_W-1:0] phys, logic [FRAME_W-1:0] frame,
                               logic hit, logic fault,
                               logic [CNT_W-1:0] hits, logic [CNT_W-1:0] faults);
      translation_t want;
      if (pending_translations.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none, actual physical 0x%0h",
                 $time, phys);
        return;
      end
      want = pending_translations.pop_front();
      words_checked++;
      compare_field("physical_address", want.phys, phys);
      compare_field("frame_number", want.frame, frame);
      compare_field("tlb_hit", want.hit, hit);
      compare_field("page_fault", want.fault, fault);
      compare_field("hit_total", want.hits, hits);
      compare_field("fault_total", want.faults, faults);
    endfunction
  endclass
endpackage

module tb;
  localparam int ADDR_W     = tpt_pkg::ADDR_W;
  localparam int FRAME_W    = tpt_pkg::FRAME_W;
  localparam int CNT_W      = tpt_pkg::CNT_W;
  localparam int TLB_DEPTH  = translate_check_pkg::TLB_DEPTH;
  localparam int PAGE_SLOTS = translate_check_pkg::PAGE_SLOTS;
  localparam int OFFSET_W   = translate_check_pkg::OFFSET_W;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADDR_W-1:0]   logical_address = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   physical_address;
  logic [FRAME_W-1:0]  frame_number;
  logic                tlb_hit;
  logic                page_fault;
  logic [CNT_W-1:0]    hit_total;
  logic [CNT_W-1:0]    fault_total;

  translate_check_pkg::translation_scoreboard sb = new();
  bit tail_phase = 1'b0;
  int gap_pct    = 20;
  int words_sent = 0;

  tlb_page_table_translator_unit #(
    .TLB_ENTRIES (TLB_DEPTH),
    .PAGE_COUNT  (PAGE_SLOTS),
    .OFFSET_BITS (OFFSET_W)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive one address word, with an optional idle burst ahead of it
  task automatic send_word(input logic [ADDR_W-1:0] addr);
    int gap;
    if (words_sent % 50 == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
    end
    if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    logical_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_address(addr);
    words_sent++;
  endtask

  // Hold the sender until every expected word has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
    endcase
  endfunction

  // Hit a random working set of pages, with some fully random noise
  task automatic run_working_set(input int count, input int set_min, input int set_max);
    int hot_pages[$];
    int n;
    int k;
    int page;
    for (n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        hot_pages.delete();
        for (k = $urandom_range(set_min, set_max); k > 0; k--)
          hot_pages.push_back($urandom_range(0, PAGE_SLOTS - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)));
      end else begin
        page = hot_pages[$urandom_range(0, hot_pages.size() - 1)];
        send_word({FRAME_W'(page), pick_offset()});
      end
    end
  endtask

  // Touch every page once in shuffled order so the frame counter wraps
  task automatic sweep_all_pages();
    int order[PAGE_SLOTS];
    int i;
    int j;
    int swap;
    for (i = 0; i < PAGE_SLOTS; i++) order[i] = i;
    for (i = PAGE_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (i = 0; i < PAGE_SLOTS; i++) send_word({FRAME_W'(order[i]), pick_offset()});
  endtask

  // Accept result words with random stall bursts and long ready stretches
  initial begin
    int span;
    @(posedge clk);
    forever begin
      if (tail_phase) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 14);
        repeat (span) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(physical_address, frame_number, tlb_hit, page_fault,
                      hit_total, fault_total);
  end

  initial begin
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // page 0 must miss out of reset, then hit; same for the top page
    send_word(16'h0000);
    send_word(16'h00FF);
    send_word(16'hFFFF);
    send_word(16'hFF00);
    // fill past the TLB depth so page 0 drops out, and its refill evicts page 255
    for (p = 1; p < 16; p++) send_word({FRAME_W'(p), OFFSET_W'(p * 17)});
    send_word(16'h00A5);
    send_word(16'hFF5A);
    send_word(16'h0F80);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'h5555);
    send_word(16'hAAAA);
    hold_until_drained();

    // small sets mostly hit, larger sets thrash the TLB into the page table
    run_working_set(300, 1, 12);
    hold_until_drained();
    run_working_set(300, 17, 40);
    sweep_all_pages();
    run_working_set(150, 1, 24);
    tail_phase = 1'b1;
    run_working_set(150, 1, 24);

    // drain and let any stray word show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Translated %0d words: %0d TLB hits, %0d page table hits, %0d page faults.",
             sb.words_checked, sb.hit_cnt, sb.table_hits, sb.fault_cnt);
    $display("Directed eviction and page 0 cases, working sets and a full page sweep ran.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS tlb_page_table_translator_unit");
    end else begin
      $display("FAIL tlb_page_table_translator_unit");
    end
    $finish;
  end

  // Bound the run well above the slowest legal schedule
  initial begin
    #5_000_000;
    $display("FAIL tlb_page_table_translator_unit");
    $finish;
  end
endmodule
